// File: src/iqos_pkg.sv
// Shared constants, codes and handshake structs for the issue queue with
// oldest-ready select. No dependencies; used by every other file.
package iqos_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int GROUP_WIDTH = 4;

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_RAW = $clog2(QUEUE_DEPTH + 1);
  localparam int CNT_W   = (CNT_RAW > 5) ? CNT_RAW : 5;

  localparam int OP_W   = 2;
  localparam int ST_W   = 2;
  localparam int TAG_W  = 32;
  localparam int AGE_W  = 32;
  localparam int PAY_W  = 64;
  localparam int FREE_W = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_ISSUE  = 2'd1;
  localparam logic [OP_W-1:0] OP_WAKEUP = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

  localparam logic [ST_W-1:0] ST_OK            = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL          = 2'd1;
  localparam logic [ST_W-1:0] ST_NONE_READY    = 2'd2;
  localparam logic [ST_W-1:0] ST_AGE_EXHAUSTED = 2'd3;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture the request
    logic scan_start;  // reset the age scan
    logic scan_step;   // fold one entry into the scan
    logic finish;      // apply the request and register the result
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_issue;
    logic scan_last;
  } dp_stat_t;

endpackage

// File: src/iqos_ctrl.sv
// Control state machine: accepts requests and sequences execute and age scan.
// Depends on iqos_pkg.
module iqos_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  iqos_pkg::dp_stat_t stat,
  output iqos_pkg::ctl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_issue) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.scan_last) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: src/iqos_dp.sv
// Datapath: entry storage, wakeup compare, lowest-free-slot pick, serial
// oldest-ready scan and the result registers. Depends on iqos_pkg.
module iqos_dp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  iqos_pkg::ctl_cmd_t                      cmd,
  output iqos_pkg::dp_stat_t                      stat,
  input  logic [iqos_pkg::OP_W-1:0]               in_opcode,
  input  logic [iqos_pkg::TAG_W-1:0]              in_src1_tag_or_value,
  input  logic                                    in_src1_ready_in,
  input  logic [iqos_pkg::TAG_W-1:0]              in_src2_tag_or_value,
  input  logic                                    in_src2_ready_in,
  input  logic [iqos_pkg::PAY_W-1:0]              in_instr_payload,
  input  logic [iqos_pkg::TAG_W-1:0]              in_wakeup_tag,
  output logic                                    out_valid,
  output logic [iqos_pkg::ST_W-1:0]               out_status,
  output logic [iqos_pkg::TAG_W-1:0]              out_issued_src1,
  output logic [iqos_pkg::TAG_W-1:0]              out_issued_src2,
  output logic [iqos_pkg::PAY_W-1:0]              out_issued_payload,
  output logic [iqos_pkg::FREE_W-1:0]             out_free_count,
  output logic                                    out_group_fits
);

  localparam int DEPTH = iqos_pkg::QUEUE_DEPTH;

  // captured request
  logic [iqos_pkg::OP_W-1:0]  op_r;
  logic [iqos_pkg::TAG_W-1:0] req_src1_r, req_src2_r, req_wtag_r;
  logic                       req_rdy1_r, req_rdy2_r;
  logic [iqos_pkg::PAY_W-1:0] req_pay_r;

  // entry storage
  logic [DEPTH-1:0]           valid_r, valid_nxt;
  logic [DEPTH-1:0]           rdy1_r, rdy1_nxt;
  logic [DEPTH-1:0]           rdy2_r, rdy2_nxt;
  logic [iqos_pkg::AGE_W-1:0] age_r  [DEPTH];
  logic [iqos_pkg::TAG_W-1:0] src1_r [DEPTH];
  logic [iqos_pkg::TAG_W-1:0] src2_r [DEPTH];
  logic [iqos_pkg::PAY_W-1:0] pay_r  [DEPTH];

  logic [iqos_pkg::AGE_W-1:0] youngest_r;
  iqos_pkg::cnt_t             free_cnt_r, free_cnt_nxt;

  // scan state
  iqos_pkg::idx_t             scan_idx_r, best_idx_r;
  logic [iqos_pkg::AGE_W-1:0] best_age_r;
  logic                       found_r;

  // result registers
  logic                       out_valid_r;
  logic [iqos_pkg::ST_W-1:0]  out_status_r;
  logic [iqos_pkg::TAG_W-1:0] out_src1_r, out_src2_r;
  logic [iqos_pkg::PAY_W-1:0] out_pay_r;
  logic [iqos_pkg::FREE_W-1:0] out_free_r;
  logic                       out_fits_r;

  iqos_pkg::idx_t            free_idx, pick_idx;
  logic                      cand, take, pick_found;
  logic                      is_insert, is_issue, is_wakeup;
  logic                      q_full, age_done, ins_ok, iss_ok;
  logic [iqos_pkg::ST_W-1:0] status_c;

  assign is_insert = (op_r == iqos_pkg::OP_INSERT);
  assign is_issue  = (op_r == iqos_pkg::OP_ISSUE);
  assign is_wakeup = (op_r == iqos_pkg::OP_WAKEUP);

  assign stat.is_issue  = is_issue;
  assign stat.scan_last = (scan_idx_r == iqos_pkg::IDX_W'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= in_opcode;
      req_src1_r <= in_src1_tag_or_value;
      req_rdy1_r <= in_src1_ready_in;
      req_src2_r <= in_src2_tag_or_value;
      req_rdy2_r <= in_src2_ready_in;
      req_pay_r  <= in_instr_payload;
      req_wtag_r <= in_wakeup_tag;
    end
  end

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_idx = iqos_pkg::IDX_W'(i);
    end
  end

  // one entry of the oldest-ready scan per cycle
  assign cand = valid_r[scan_idx_r] & rdy1_r[scan_idx_r] & rdy2_r[scan_idx_r];
  assign take = cand && (!found_r || (age_r[scan_idx_r] < best_age_r));
  assign pick_idx   = take ? scan_idx_r : best_idx_r;
  assign pick_found = take | found_r;

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx_r <= '0;
      found_r    <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + 1'b1;
      if (take) begin
        found_r    <= 1'b1;
        best_idx_r <= scan_idx_r;
        best_age_r <= age_r[scan_idx_r];
      end
    end
  end

  assign q_full   = (free_cnt_r == '0);
  assign age_done = (youngest_r == '1);
  assign ins_ok   = cmd.finish && is_insert && !q_full && !age_done;
  assign iss_ok   = cmd.finish && is_issue && pick_found;

  always_comb begin
    status_c = iqos_pkg::ST_OK;
    if (is_insert) begin
      if (q_full)        status_c = iqos_pkg::ST_FULL;
      else if (age_done) status_c = iqos_pkg::ST_AGE_EXHAUSTED;
    end else if (is_issue && !pick_found) begin
      status_c = iqos_pkg::ST_NONE_READY;
    end
  end

  always_comb begin
    valid_nxt    = valid_r;
    rdy1_nxt     = rdy1_r;
    rdy2_nxt     = rdy2_r;
    free_cnt_nxt = free_cnt_r;
    if (ins_ok) begin
      valid_nxt[free_idx] = 1'b1;
      rdy1_nxt[free_idx]  = req_rdy1_r;
      rdy2_nxt[free_idx]  = req_rdy2_r;
      free_cnt_nxt        = free_cnt_r - 1'b1;
    end
    if (iss_ok) begin
      valid_nxt[pick_idx] = 1'b0;
      free_cnt_nxt        = free_cnt_r + 1'b1;
    end
    if (cmd.finish && is_wakeup) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (valid_r[i] && (src1_r[i] == req_wtag_r)) rdy1_nxt[i] = 1'b1;
        if (valid_r[i] && (src2_r[i] == req_wtag_r)) rdy2_nxt[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      youngest_r <= '0;
      free_cnt_r <= iqos_pkg::CNT_W'(DEPTH);
    end else begin
      valid_r    <= valid_nxt;
      free_cnt_r <= free_cnt_nxt;
      if (ins_ok) youngest_r <= youngest_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rdy1_r <= rdy1_nxt;
    rdy2_r <= rdy2_nxt;
    if (ins_ok) begin
      age_r[free_idx]  <= youngest_r + 1'b1;
      src1_r[free_idx] <= req_src1_r;
      src2_r[free_idx] <= req_src2_r;
      pay_r[free_idx]  <= req_pay_r;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= status_c;
      out_src1_r   <= iss_ok ? src1_r[pick_idx] : '0;
      out_src2_r   <= iss_ok ? src2_r[pick_idx] : '0;
      out_pay_r    <= iss_ok ? pay_r[pick_idx] : '0;
      out_free_r   <= (free_cnt_nxt > iqos_pkg::CNT_W'(31)) ? '1
                    : free_cnt_nxt[iqos_pkg::FREE_W-1:0];
      out_fits_r   <= (free_cnt_nxt >= iqos_pkg::CNT_W'(iqos_pkg::GROUP_WIDTH));
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_issued_src1    = out_src1_r;
  assign out_issued_src2    = out_src2_r;
  assign out_issued_payload = out_pay_r;
  assign out_free_count     = out_free_r;
  assign out_group_fits     = out_fits_r;

endmodule

// File: src/issue_queue_oldest_ready_select.sv
// Issue queue with oldest-ready select: top level, controller plus datapath.
// Depends on iqos_pkg, iqos_ctrl and iqos_dp.
//
// A request (insert, issue or wakeup) is taken at a rising edge where start
// is high and busy is low; the in_ ports are sampled at that edge. Exactly one
// result follows per request: out_valid is high for a single cycle and the
// out_ ports hold the result during that cycle. The receiver has no way to
// stall, so every result must be taken when shown.
// Sequence, from the accepting edge to the result:
//   insert, wakeup, nop: executed in S_EXEC and the result registered; the
//   next request can be taken in the cycle the result is shown.
//   issue: S_EXEC, then the age scan in S_SCAN, which walks all QUEUE_DEPTH
//   entries, one per cycle, against the oldest ready entry found so far.
// Wakeup tag compares run across all entries in parallel, combinationally.
// Reset (rst_n low, synchronous) empties the queue and zeroes the age
// counter; no clearing pass is needed, entry contents are written on insert.
module issue_queue_oldest_ready_select (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [iqos_pkg::OP_W-1:0]    in_opcode,
  input  logic [iqos_pkg::TAG_W-1:0]   in_src1_tag_or_value,
  input  logic                         in_src1_ready_in,
  input  logic [iqos_pkg::TAG_W-1:0]   in_src2_tag_or_value,
  input  logic                         in_src2_ready_in,
  input  logic [iqos_pkg::PAY_W-1:0]   in_instr_payload,
  input  logic [iqos_pkg::TAG_W-1:0]   in_wakeup_tag,
  output logic                         out_valid,
  output logic [iqos_pkg::ST_W-1:0]    out_status,
  output logic [iqos_pkg::TAG_W-1:0]   out_issued_src1,
  output logic [iqos_pkg::TAG_W-1:0]   out_issued_src2,
  output logic [iqos_pkg::PAY_W-1:0]   out_issued_payload,
  output logic [iqos_pkg::FREE_W-1:0]  out_free_count,
  output logic                         out_group_fits
);

  iqos_pkg::ctl_cmd_t cmd;
  iqos_pkg::dp_stat_t stat;

  iqos_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  iqos_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_opcode            (in_opcode),
    .in_src1_tag_or_value (in_src1_tag_or_value),
    .in_src1_ready_in     (in_src1_ready_in),
    .in_src2_tag_or_value (in_src2_tag_or_value),
    .in_src2_ready_in     (in_src2_ready_in),
    .in_instr_payload     (in_instr_payload),
    .in_wakeup_tag        (in_wakeup_tag),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_issued_src1      (out_issued_src1),
    .out_issued_src2      (out_issued_src2),
    .out_issued_payload   (out_issued_payload),
    .out_free_count       (out_free_count),
    .out_group_fits       (out_group_fits)
  );

`ifndef SYNTH
  // a result only ever closes out a request in flight
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a request in flight");

  // one result per request: never two strobes in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe repeated");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == iqos_pkg::ST_FULL)) |-> (out_free_count == '0))
    else $error("queue full reported with free entries");
`endif

endmodule
